// ----- rtl/efme_pkg.sv -----
// Package: shared types and constants for the event queue with match extract.
package efme_pkg;
    localparam int unsigned QueueDepthDefault = 16;

    typedef enum logic [2:0] {
        OP_PUSH  = 3'd0,
        OP_POP   = 3'd1,
        OP_MATCH = 3'd2,
        OP_EXACT = 3'd3,
        OP_CLEAR = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        OUT_OK       = 2'd0,
        OUT_NONE     = 2'd1,
        OUT_OVF_NOW  = 2'd2,
        OUT_OVF_HELD = 2'd3
    } t_outcome;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic exec;
    } t_cmd;
endpackage

// ----- rtl/event_fifo_with_match_extract_top.sv -----
// Top level: event queue with associative search and remove.
// Flow: an accepted item goes into the operand registers; the execute state
// runs the compare-and-compact pass over all cells and writes the result
// register, shown with o_valid; no new item is taken until its hand-off.
// Reset: synchronous active low; queue empties, overflow status and limit clear.
// Cell contents are not cleared; only entries below the fill count are read.
module event_fifo_with_match_extract_top #(
    parameter int unsigned QUEUE_DEPTH = efme_pkg::QueueDepthDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [4:0]  i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_op,
    input  logic [15:0] i_proc_id,
    input  logic [15:0] i_line_id,
    input  logic [31:0] i_event_num,
    input  logic [31:0] i_message,
    input  logic        i_skip_proc,
    input  logic        i_skip_line,
    input  logic        i_skip_event,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_outcome,
    output logic [15:0] o_out_proc,
    output logic [15:0] o_out_line,
    output logic [31:0] o_out_event,
    output logic [31:0] o_out_message,
    output logic [4:0]  o_fill_level
);
    import efme_pkg::*;

    t_cmd cmd;
    logic [4:0] r_limit;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= '0;
        end else if (i_cfg_valid) begin
            r_limit <= i_cfg_data;
        end
    end

    efme_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .o_valid, .i_stall, .o_cmd(cmd)
    );

    efme_dp #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .i_limit(r_limit),
        .i_op, .i_proc_id, .i_line_id, .i_event_num, .i_message,
        .i_skip_proc, .i_skip_line, .i_skip_event,
        .o_outcome, .o_out_proc, .o_out_line, .o_out_event, .o_out_message,
        .o_fill_level
    );
endmodule

// ----- rtl/efme_ctrl.sv -----
// Controller: sequences capture, execute and result hand-off.
module efme_ctrl (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    output logic o_valid,
    input  logic i_stall,
    output efme_pkg::t_cmd o_cmd
);
    import efme_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_stall    = 1'b1;
        o_valid    = 1'b0;
        o_cmd.load = 1'b0;
        o_cmd.exec = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = ST_OUT;
            end
            ST_OUT: begin
                o_valid = 1'b1;
                if (!i_stall) begin
                    o_stall = 1'b0;
                    if (i_valid) begin
                        o_cmd.load = 1'b1;
                        n_state    = ST_EXEC;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    a_out_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.exec |=> o_valid) else $error("result not presented after execute");
    a_no_load_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> !o_stall) else $error("load while stalled");
    a_exec_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> o_cmd.exec) else $error("load not followed by execute");
endmodule

// ----- rtl/efme_dp.sv -----
// Datapath: entry cells, parallel compare, compaction and result register.
module efme_dp #(
    parameter int unsigned QUEUE_DEPTH = efme_pkg::QueueDepthDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  efme_pkg::t_cmd i_cmd,
    input  logic [4:0]  i_limit,
    input  logic [2:0]  i_op,
    input  logic [15:0] i_proc_id,
    input  logic [15:0] i_line_id,
    input  logic [31:0] i_event_num,
    input  logic [31:0] i_message,
    input  logic        i_skip_proc,
    input  logic        i_skip_line,
    input  logic        i_skip_event,
    output logic [1:0]  o_outcome,
    output logic [15:0] o_out_proc,
    output logic [15:0] o_out_line,
    output logic [31:0] o_out_event,
    output logic [31:0] o_out_message,
    output logic [4:0]  o_fill_level
);
    import efme_pkg::*;

    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    logic [95:0] r_cell [QUEUE_DEPTH];
    logic [CW-1:0] r_count;
    logic r_ovf;
    logic [2:0] r_op;
    logic [15:0] r_kp, r_kl;
    logic [31:0] r_ke, r_km;
    logic r_sp, r_sl, r_se;

    logic [QUEUE_DEPTH-1:0] hit, first;
    logic [IW-1:0] pos;
    logic found;
    logic full;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= i_op; r_kp <= i_proc_id; r_kl <= i_line_id;
            r_ke <= i_event_num; r_km <= i_message;
            r_sp <= i_skip_proc; r_sl <= i_skip_line; r_se <= i_skip_event;
        end
    end

    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (r_op == OP_POP) begin
                hit[i] = (i == 0);
            end else if (r_op == OP_MATCH) begin
                hit[i] = (r_sp || r_cell[i][95:80] == r_kp)
                      && (r_sl || r_cell[i][79:64] == r_kl)
                      && (r_se || r_cell[i][63:32] == r_ke);
            end else begin
                hit[i] = r_cell[i] == {r_kp, r_kl, r_ke, r_km};
            end
            hit[i] = hit[i] && (CW'(i) < r_count);
        end
        first = hit & (~hit + 1'b1);
        found = |hit;
        pos   = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (first[i]) pos = pos | IW'(i);
        end
        full = ((i_limit != 5'd0) && ({{CW{1'b0}}, i_limit} <= (CW+5)'(r_count)))
            || (r_count == CW'(QUEUE_DEPTH));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else if (i_cmd.exec) begin
            priority case (r_op)
                OP_PUSH: begin
                    if (!r_ovf && !full) begin
                        r_count <= r_count + 1'b1;
                    end else if (!r_ovf) begin
                        r_ovf <= 1'b1;
                    end
                end
                OP_POP, OP_MATCH, OP_EXACT: begin
                    if (found) r_count <= r_count - 1'b1;
                end
                OP_CLEAR: r_count <= '0;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            if (r_op == OP_PUSH && !r_ovf && !full) begin
                r_cell[r_count[IW-1:0]] <= {r_kp, r_kl, r_ke, r_km};
            end else if (found && (r_op == OP_POP || r_op == OP_MATCH
                                   || r_op == OP_EXACT)) begin
                for (int i = 0; i + 1 < QUEUE_DEPTH; i++) begin
                    if (IW'(i) >= pos) r_cell[i] <= r_cell[i+1];
                end
            end
        end
    end

    logic [CW-1:0] n_count;
    logic [1:0]    n_outcome;
    logic [95:0]   n_data;

    always_comb begin
        n_count   = r_count;
        n_outcome = OUT_OK;
        n_data    = '0;
        priority case (r_op)
            OP_PUSH: begin
                if (r_ovf) n_outcome = OUT_OVF_HELD;
                else if (full) n_outcome = OUT_OVF_NOW;
                else n_count = r_count + 1'b1;
            end
            OP_POP, OP_MATCH, OP_EXACT: begin
                if (found) begin
                    n_data  = r_cell[pos];
                    n_count = r_count - 1'b1;
                end else begin
                    n_outcome = OUT_NONE;
                end
            end
            OP_CLEAR: n_count = '0;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            o_outcome     <= n_outcome;
            o_out_proc    <= n_data[95:80];
            o_out_line    <= n_data[79:64];
            o_out_event   <= n_data[63:32];
            o_out_message <= n_data[31:0];
            o_fill_level  <= 5'(n_count);
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH)) else $error("count beyond depth");
    a_ovf_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |=> r_ovf) else $error("overflow status dropped");
    a_found_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        found |-> r_count != '0) else $error("hit in empty queue");
endmodule
